// ===== rtl/etfi_pkg.sv =====
// Package for the escape-time fractal iterator: widths, fixed-point constants,
// register indexes and the command and status types between controller and datapath.
// No dependencies.
package etfi_pkg;

	localparam int FRAC_BITS     = 24;
	localparam int CW            = 32;
	localparam int ZW            = 40;
	localparam int HALF          = ZW / 2;
	localparam int PP_W          = ZW + HALF;
	localparam int PROD_W        = 2 * ZW;
	localparam int SQ_W          = 63;
	localparam int M_W           = SQ_W + 1;
	localparam int SUM_W         = ZW + 2;
	localparam int CNT_W         = 16;
	localparam int THR_W         = 16;
	localparam int THR_FRAC_BITS = 8;
	localparam int T2_SHIFT      = FRAC_BITS - 2 * THR_FRAC_BITS;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [ZW-1:0]   ZMAX   = {1'b0, {(ZW-1){1'b1}}};
	localparam logic [ZW-1:0]   ZMIN   = {1'b1, {(ZW-1){1'b0}}};
	localparam logic [SQ_W-1:0] SQ_CAP = {1'b1, {(SQ_W-1){1'b0}}};

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd10752;
	localparam logic [CNT_W-1:0] LIMIT_RESET     = 16'd40;

	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT  = 1'd1;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic update;
	} etfi_cmd_t;

	typedef struct packed {
		logic beyond_radius;
	} etfi_sts_t;

endpackage

// ===== rtl/etfi_dp.sv =====
// Datapath of the escape-time fractal iterator: holds c and z, forms the three
// squared/cross products with split multipliers and performs the saturating update.
// Depends on etfi_pkg.
module etfi_dp (
	input  logic                                 clk,
	input  etfi_pkg::etfi_cmd_t                  cmd,
	input  logic signed [etfi_pkg::CW-1:0]       point_real,
	input  logic signed [etfi_pkg::CW-1:0]       point_imag,
	input  logic        [etfi_pkg::THR_W-1:0]    threshold,
	output etfi_pkg::etfi_sts_t                  sts
);
	import etfi_pkg::*;

	logic signed [CW-1:0]   c_real_q;
	logic signed [CW-1:0]   c_imag_q;
	logic signed [ZW-1:0]   zr_q;
	logic signed [ZW-1:0]   zi_q;
	logic [PP_W-1:0]        pp_rr_lo_q;
	logic [PP_W-1:0]        pp_ii_lo_q;
	logic [PP_W-1:0]        pp_ri_lo_q;
	logic [PP_W-1:0]        pp_rr_hi_q;
	logic [PP_W-1:0]        pp_ii_hi_q;
	logic [PP_W-1:0]        pp_ri_hi_q;
	logic [SQ_W-1:0]        sq_rr_q;
	logic [SQ_W-1:0]        sq_ii_q;
	logic [SQ_W-1:0]        pr_ri_q;
	logic [M_W-1:0]         t2_q;
	logic [2*THR_W-1:0]     thr_sq;
	logic [ZW-1:0]          mr;
	logic [ZW-1:0]          mi;
	logic [ZW-1:0]          rr_v;
	logic [ZW-1:0]          ii_v;
	logic [ZW-1:0]          ri_v;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_i;
	logic [M_W-1:0]         mag_sq;

	function automatic logic [SQ_W-1:0] shift_cap(input logic [PP_W-1:0] lo,
			input logic [PP_W-1:0] hi);
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] s;
		p = (PROD_W'(hi) << HALF) + PROD_W'(lo);
		s = p >> FRAC_BITS;
		if (s >= PROD_W'(SQ_CAP)) begin
			return SQ_CAP;
		end
		return s[SQ_W-1:0];
	endfunction

	function automatic logic [ZW-1:0] sat_pos(input logic [SQ_W-1:0] r);
		if (r >= SQ_W'(ZMAX)) begin
			return ZMAX;
		end
		return r[ZW-1:0];
	endfunction

	function automatic logic [ZW-1:0] sat_neg(input logic [SQ_W-1:0] r);
		if (r >= SQ_W'(ZMIN)) begin
			return ZMIN;
		end
		return ZW'(-r[ZW-1:0]);
	endfunction

	function automatic logic signed [ZW-1:0] sat_z(input logic signed [SUM_W-1:0] v);
		if ((&v[SUM_W-1:ZW-1]) || !(|v[SUM_W-1:ZW-1])) begin
			return v[ZW-1:0];
		end
		return v[SUM_W-1] ? ZMIN : ZMAX;
	endfunction

	always_comb begin
		mr     = zr_q[ZW-1] ? ZW'(-zr_q) : ZW'(zr_q);
		mi     = zi_q[ZW-1] ? ZW'(-zi_q) : ZW'(zi_q);
		thr_sq = (2*THR_W)'(threshold) * (2*THR_W)'(threshold);
		rr_v   = sat_pos(sq_rr_q);
		ii_v   = sat_pos(sq_ii_q);
		ri_v   = (zr_q[ZW-1] ^ zi_q[ZW-1]) ? sat_neg(pr_ri_q) : sat_pos(pr_ri_q);
		sum_r  = SUM_W'($signed(rr_v)) - SUM_W'($signed(ii_v)) + SUM_W'(c_real_q);
		sum_i  = (SUM_W'($signed(ri_v)) <<< 1) + SUM_W'(c_imag_q);
		mag_sq = {1'b0, sq_rr_q} + {1'b0, sq_ii_q};
		sts.beyond_radius = mag_sq > t2_q;
	end

	always_ff @(posedge clk) begin
		t2_q <= M_W'(thr_sq) << T2_SHIFT;
		if (cmd.load) begin
			c_real_q <= point_real;
			c_imag_q <= point_imag;
			zr_q     <= '0;
			zi_q     <= '0;
		end
		if (cmd.mul_lo) begin
			pp_rr_lo_q <= PP_W'(mr) * PP_W'(mr[HALF-1:0]);
			pp_ii_lo_q <= PP_W'(mi) * PP_W'(mi[HALF-1:0]);
			pp_ri_lo_q <= PP_W'(mr) * PP_W'(mi[HALF-1:0]);
		end
		if (cmd.mul_hi) begin
			pp_rr_hi_q <= PP_W'(mr) * PP_W'(mr[ZW-1:HALF]);
			pp_ii_hi_q <= PP_W'(mi) * PP_W'(mi[ZW-1:HALF]);
			pp_ri_hi_q <= PP_W'(mr) * PP_W'(mi[ZW-1:HALF]);
		end
		if (cmd.sum) begin
			sq_rr_q <= shift_cap(pp_rr_lo_q, pp_rr_hi_q);
			sq_ii_q <= shift_cap(pp_ii_lo_q, pp_ii_hi_q);
			pr_ri_q <= shift_cap(pp_ri_lo_q, pp_ri_hi_q);
		end
		if (cmd.update) begin
			zr_q <= sat_z(sum_r);
			zi_q <= sat_z(sum_i);
		end
	end

endmodule

// ===== rtl/etfi_ctrl.sv =====
// Controller of the escape-time fractal iterator: sequences each update, counts
// steps, decides escape or limit and holds the result register.
// Depends on etfi_pkg.
module etfi_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              escaped,
	output logic [etfi_pkg::CNT_W-1:0]        escape_count,
	input  logic [etfi_pkg::CNT_W-1:0]        limit,
	input  etfi_pkg::etfi_sts_t               sts,
	output etfi_pkg::etfi_cmd_t               cmd
);
	import etfi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_SUM,
		S_EVAL
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] step_q;
	logic             out_valid_q;
	logic             escaped_q;
	logic [CNT_W-1:0] count_q;
	logic             hit;
	logic             finish;
	logic             out_free;

	assign hit          = (step_q != '0) && sts.beyond_radius;
	assign finish       = hit || (step_q == limit);
	assign out_free     = !out_valid_q || out_ready;
	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign escaped      = escaped_q;
	assign escape_count = count_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load   = in_valid;
			S_MUL_LO: cmd.mul_lo = 1'b1;
			S_MUL_HI: cmd.mul_hi = 1'b1;
			S_SUM:    cmd.sum    = 1'b1;
			S_EVAL:   cmd.update = !finish;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			escaped_q   <= 1'b0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && out_ready && !(state_q == S_EVAL && finish)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_SUM;
				S_SUM:    state_q <= S_EVAL;
				S_EVAL: begin
					if (finish) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							escaped_q   <= hit;
							count_q     <= hit ? step_q - CNT_W'(1) : step_q;
							state_q     <= S_IDLE;
						end
					end else begin
						step_q  <= step_q + CNT_W'(1);
						state_q <= S_MUL_LO;
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_step_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (step_q <= limit))
		else $error("step count passed the iteration limit");

	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EVAL))
		else $error("result appeared outside the evaluation step");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul_lo, cmd.mul_hi, cmd.sum, cmd.update}))
		else $error("more than one datapath command at once");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (count_q <= limit))
		else $error("escape count above the iteration limit");
`endif

endmodule

// ===== rtl/escape_time_fractal_iterator_unit.sv =====
// Top level of the escape-time fractal iterator: configuration registers and
// the controller and datapath instances.
// Depends on etfi_pkg, etfi_ctrl and etfi_dp.
//
// Channel   Signals                             Transfer when
// input     in_valid, in_ready, point_*         in_valid & in_ready
// output    out_valid, out_ready, escaped, ...  out_valid & out_ready
// config    cfg_wr_en, cfg_index, cfg_data      cfg_wr_en
//
// Each z update steps through the states MUL_LO and MUL_HI for the split 40x20
// multipliers, SUM to sum and cap the products, and EVAL to test the radius and update z.
// One point is in work at a time; a new point is taken while a result waits.
// A stalled result holds the unit in its final step until the output register frees.
// Reset restores threshold 42.0 and limit 40 and empties the output register.
module escape_time_fractal_iterator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [etfi_pkg::CW-1:0]        point_real,
	input  logic signed [etfi_pkg::CW-1:0]        point_imag,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  escaped,
	output logic [etfi_pkg::CNT_W-1:0]            escape_count,
	input  logic                                  cfg_wr_en,
	input  logic [etfi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [etfi_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import etfi_pkg::*;

	logic [THR_W-1:0] threshold_q;
	logic [CNT_W-1:0] limit_q;
	etfi_cmd_t        cmd;
	etfi_sts_t        sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			limit_q     <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ESCAPE_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_ITERATION_LIMIT:  limit_q     <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	etfi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.escaped      (escaped),
		.escape_count (escape_count),
		.limit        (limit_q),
		.sts          (sts),
		.cmd          (cmd)
	);

	etfi_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.point_real (point_real),
		.point_imag (point_imag),
		.threshold  (threshold_q),
		.sts        (sts)
	);

endmodule
